// ===== rtl/core/wps_pkg.sv =====
package wps_pkg;

  // Table geometry
  localparam int SLOTS       = 28;
  localparam int WEIGHT_BITS = 8;
  localparam int ADDR_W      = $clog2(SLOTS);
  localparam int CNT_W       = $clog2(SLOTS + 1);

  // Field widths
  localparam int OP_W     = 2;
  localparam int WEIGHT_W = 8;
  localparam int SUM_W    = 13;
  localparam int SLOT_W   = 5;
  localparam int STAT_W   = 2;

  localparam logic [SUM_W-1:0]    SUM_MAX     = {SUM_W{1'b1}};
  localparam logic [WEIGHT_W-1:0] WEIGHT_MASK = WEIGHT_W'((1 << WEIGHT_BITS) - 1);

  // Operation codes
  localparam logic [OP_W-1:0] OP_RESTART = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND  = 2'd1;
  localparam logic [OP_W-1:0] OP_DRAW    = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd3;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_number;
    logic [SUM_W-1:0]  running_total;
    logic [STAT_W-1:0] status;
  } wps_res_t;

endpackage

// ===== rtl/core/weighted_prize_select.sv =====
// Channel | Handshake           | Fields                                          | Dir
// request | in_valid/in_ready   | in_operation, in_weight, in_random_value        | in
// result  | out_valid/out_ready | out_slot_number, out_running_total, out_status  | out
//
// One request at a time. Restart, append and draws that need no search (empty,
// out of range, single slot) go from idle straight to the response state;
// a searching draw first stays in the search state, one probe of the
// running-sum memory per cycle through its single read port.
// Reset (rst_n low, synchronous) empties the table; memory contents stay.
// A result waits in the output register while the next request is taken;
// a second result holds in the controller until out_ready frees the register.
module weighted_prize_select (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [wps_pkg::OP_W-1:0]      in_operation,
  input  logic [wps_pkg::WEIGHT_W-1:0]  in_weight,
  input  logic [wps_pkg::SUM_W-1:0]     in_random_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [wps_pkg::SLOT_W-1:0]    out_slot_number,
  output logic [wps_pkg::SUM_W-1:0]     out_running_total,
  output logic [wps_pkg::STAT_W-1:0]    out_status
);
  import wps_pkg::*;

  logic              res_valid;
  logic              res_ready;
  wps_res_t          res;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [SUM_W-1:0]  mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [SUM_W-1:0]  mem_rdata;
  logic              out_valid_r;
  wps_res_t          out_res_r;

  wps_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_weight       (in_weight),
    .in_random_value (in_random_value),
    .res_valid       (res_valid),
    .res             (res),
    .res_ready       (res_ready),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_re          (mem_re),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata)
  );

  wps_ram #(
    .DEPTH (SLOTS),
    .WIDTH (SUM_W)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr   (mem_raddr),
    .rdata_r (mem_rdata)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_slot_number   = out_res_r.slot_number;
  assign out_running_total = out_res_r.running_total;
  assign out_status        = out_res_r.status;

endmodule

// ===== rtl/core/wps_ram.sv =====
module wps_ram #(
  parameter int DEPTH = 28,
  parameter int WIDTH = 13
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/wps_ctrl.sv =====
module wps_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [wps_pkg::OP_W-1:0]      in_operation,
  input  logic [wps_pkg::WEIGHT_W-1:0]  in_weight,
  input  logic [wps_pkg::SUM_W-1:0]     in_random_value,
  output logic                          res_valid,
  output wps_pkg::wps_res_t             res,
  input  logic                          res_ready,
  output logic                          mem_we,
  output logic [wps_pkg::ADDR_W-1:0]    mem_waddr,
  output logic [wps_pkg::SUM_W-1:0]     mem_wdata,
  output logic                          mem_re,
  output logic [wps_pkg::ADDR_W-1:0]    mem_raddr,
  input  logic [wps_pkg::SUM_W-1:0]     mem_rdata
);
  import wps_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_RESP   = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [SUM_W-1:0]  total_r, total_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ADDR_W-1:0] lo_r, lo_nxt;
  logic [ADDR_W-1:0] hi_r, hi_nxt;
  logic [ADDR_W-1:0] mid_r, mid_nxt;
  logic [SUM_W-1:0]  rnd_r, rnd_nxt;
  wps_res_t          res_r, res_nxt;

  logic [SUM_W:0]    sum_ext;
  logic [SUM_W-1:0]  sum_sat;
  logic              full;
  logic              empty;
  logic [ADDR_W-1:0] hi_first;
  logic [ADDR_W-1:0] mid_first;
  logic              go_left;
  logic [ADDR_W-1:0] lo_srch;
  logic [ADDR_W-1:0] hi_srch;
  logic [ADDR_W:0]   lh_sum;
  logic [ADDR_W-1:0] mid_srch;
  logic [ADDR_W:0]   slot_wide;

  // Saturating running sum for append
  assign sum_ext = {1'b0, total_r} + (SUM_W + 1)'(in_weight & WEIGHT_MASK);
  assign sum_sat = (sum_ext > {1'b0, SUM_MAX}) ? SUM_MAX : sum_ext[SUM_W-1:0];

  assign full  = (count_r >= CNT_W'(SLOTS));
  assign empty = (total_r == '0) || (count_r == '0);

  // First probe of a draw: lo = 0, hi = count - 1
  assign hi_first  = ADDR_W'(count_r - CNT_W'(1));
  assign mid_first = hi_first >> 1;

  // Narrow the search window from the probe just read
  assign go_left   = (rnd_r < mem_rdata);
  assign lo_srch   = go_left ? lo_r : mid_r + ADDR_W'(1);
  assign hi_srch   = go_left ? mid_r : hi_r;
  assign lh_sum    = {1'b0, lo_srch} + {1'b0, hi_srch};
  assign mid_srch  = lh_sum[ADDR_W:1];
  assign slot_wide = {1'b0, lo_srch} + (ADDR_W + 1)'(1);

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESP);
  assign res       = res_r;

  assign mem_waddr = count_r[ADDR_W-1:0];
  assign mem_wdata = sum_sat;

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    total_nxt = total_r;
    count_nxt = count_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    rnd_nxt   = rnd_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = mid_first;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_nxt.slot_number   = '0;
          res_nxt.running_total = total_r;
          res_nxt.status        = STAT_OK;
          state_nxt             = S_RESP;
          unique case (in_operation)
            OP_RESTART: begin
              total_nxt             = '0;
              count_nxt             = '0;
              res_nxt.running_total = '0;
            end
            OP_APPEND: begin
              if (full) begin
                res_nxt.status = STAT_FULL;
              end else begin
                mem_we                = 1'b1;
                total_nxt             = sum_sat;
                count_nxt             = count_r + CNT_W'(1);
                res_nxt.running_total = sum_sat;
              end
            end
            OP_DRAW: begin
              if (empty) begin
                res_nxt.status = STAT_EMPTY;
              end else if (in_random_value >= total_r) begin
                res_nxt.status = STAT_RANGE;
              end else if (hi_first == '0) begin
                // single loaded slot: it is the answer
                res_nxt.slot_number = SLOT_W'(1);
              end else begin
                mem_re    = 1'b1;
                lo_nxt    = '0;
                hi_nxt    = hi_first;
                mid_nxt   = mid_first;
                rnd_nxt   = in_random_value;
                state_nxt = S_SEARCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SEARCH: begin
        lo_nxt = lo_srch;
        hi_nxt = hi_srch;
        if (lo_srch < hi_srch) begin
          // advance to the next probe
          mem_re    = 1'b1;
          mem_raddr = mid_srch;
          mid_nxt   = mid_srch;
        end else begin
          res_nxt.slot_number = SLOT_W'(slot_wide);
          state_nxt           = S_RESP;
        end
      end
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      total_r <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      count_r <= count_nxt;
    end
  end

  // Search window and result payload
  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    rnd_r <= rnd_nxt;
    res_r <= res_nxt;
  end

endmodule
